// ===== rtl/ntex_pkg.sv =====
// Shared constants, codes and types of the nearest texture sampler.
package ntex_pkg;

	localparam int MAX_TEXELS_DEF    = 65536;
	localparam int MAX_DIMENSION_DEF = 256;

	localparam int MODE_W    = 2;
	localparam int COORD_W   = 32;
	localparam int WADDR_W   = 16;
	localparam int TEXEL_W   = 32;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_RESET = 256;

	// Q15.16 fixed point.
	localparam int           Q_FRAC = 16;
	localparam logic [31:0]  Q_ONE  = 32'h0001_0000;
	localparam logic [31:0]  Q_HALF = 32'h0000_8000;
	localparam int           CLAMP_W = Q_FRAC + 1;

	localparam int QUEUE_DEPTH  = 4;
	localparam int RESULT_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE = 2'd0,
		MODE_CLAMP = 2'd1,
		MODE_TILE  = 2'd2
	} mode_t;

	// Work that the back end carries out for one queued item.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_ZERO  = 2'd2
	} op_t;

endpackage

// ===== rtl/ntex_fifo.sv =====
// Small register queue used between the front end, the back end and the result port.
module ntex_fifo #(
	parameter int W     = 32,
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  logic [W-1:0]                 wdata,
	input  logic                         pop,
	output logic [W-1:0]                 rdata,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          full;
	logic          do_push;
	logic          do_pop;

	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign empty   = (count_q == '0);
	assign full    = (count_q == CW'(DEPTH));
	assign count   = count_q;
	assign rdata   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// ===== rtl/ntex_front.sv =====
// Front end: accepts items, classifies them and maps sample coordinates to a texel index.
module ntex_front #(
	parameter int MAX_TEXELS    = ntex_pkg::MAX_TEXELS_DEF,
	parameter int MAX_DIMENSION = ntex_pkg::MAX_DIMENSION_DEF,
	parameter int AW            = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [ntex_pkg::MODE_W-1:0]   mode,
	input  logic [ntex_pkg::COORD_W-1:0]  s_coord,
	input  logic [ntex_pkg::COORD_W-1:0]  t_coord,
	input  logic [ntex_pkg::WADDR_W-1:0]  write_address,
	input  logic [ntex_pkg::TEXEL_W-1:0]  write_texel,
	input  logic [ntex_pkg::CFG_W-1:0]    width_cfg,
	input  logic [ntex_pkg::CFG_W-1:0]    height_cfg,
	output logic                          advance,
	input  logic                          q_full,
	output logic                          q_push,
	output ntex_pkg::op_t                 q_op,
	output logic [AW-1:0]                 q_addr,
	output logic [ntex_pkg::TEXEL_W-1:0]  q_data
);
	import ntex_pkg::*;

	localparam int CW = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
	localparam int DW = $clog2(MAX_DIMENSION + 1);
	localparam int PW = CLAMP_W + CW;
	localparam int IW = (2 * CW + 1 > AW) ? 2 * CW + 1 : AW;

	function automatic logic [DW-1:0] limit_dim(input logic [CFG_W-1:0] d);
		logic [DW-1:0] r;
		if (d == '0) begin
			r = DW'(1);
		end else if (32'(d) > 32'(MAX_DIMENSION)) begin
			r = DW'(MAX_DIMENSION);
		end else begin
			r = DW'(d);
		end
		return r;
	endfunction

	// Negative coordinates go to zero; tile keeps the fraction above one.
	function automatic logic [CLAMP_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw,
		input logic tile);
		logic [COORD_W-1:0] r;
		r = raw;
		if (raw[COORD_W-1]) begin
			r = '0;
		end else begin
			if (tile && r > Q_ONE) begin
				r = {16'h0000, r[Q_FRAC-1:0]};
			end
			if (r > Q_ONE) begin
				r = Q_ONE;
			end
		end
		return r[CLAMP_W-1:0];
	endfunction

	logic [DW-1:0]  w_lim;
	logic [DW-1:0]  h_lim;
	logic           keep;
	op_t            op_in;
	logic           tile;

	logic                v_s1, v_s2, v_s3, v_s4;
	op_t                 op_s1, op_s2, op_s3, op_s4;
	logic [AW-1:0]       addr_s1, addr_s2, addr_s3, addr_s4;
	logic [TEXEL_W-1:0]  data_s1, data_s2, data_s3, data_s4;
	logic [CLAMP_W-1:0]  cs_s1, ct_s1;
	logic [CW-1:0]       wm1_s1, hm1_s1, hm1_s2;
	logic [DW-1:0]       w_s1, w_s2, w_s3;
	logic [PW-1:0]       ps_s2, pt_s2;
	logic [CW-1:0]       col_s3, row_s3;
	logic [PW:0]         s_round;
	logic [PW:0]         t_round;
	logic [IW-1:0]       idx;
	logic                in_range;

	assign advance = !v_s4 || !q_full;
	assign q_push  = v_s4 && !q_full;
	assign q_op    = op_s4;
	assign q_addr  = addr_s4;
	assign q_data  = data_s4;

	assign w_lim = limit_dim(width_cfg);
	assign h_lim = limit_dim(height_cfg);

	always_comb begin
		keep  = 1'b0;
		op_in = OP_READ;
		tile  = 1'b0;
		unique case (mode)
			MODE_WRITE: begin
				keep  = (32'(write_address) < 32'(MAX_TEXELS));
				op_in = OP_WRITE;
			end
			MODE_CLAMP: begin
				keep = 1'b1;
			end
			MODE_TILE: begin
				keep = 1'b1;
				tile = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign s_round  = (PW+1)'(ps_s2) + (PW+1)'(Q_HALF);
	assign t_round  = (PW+1)'(pt_s2) + (PW+1)'(Q_HALF);
	assign idx      = IW'(row_s3) * IW'(w_s3) + IW'(col_s3);
	assign in_range = (64'(idx) < 64'(MAX_TEXELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= accept && keep;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1   <= op_in;
			addr_s1 <= AW'(write_address);
			data_s1 <= write_texel;
			cs_s1   <= clamp_coord(s_coord, tile);
			ct_s1   <= clamp_coord(t_coord, tile);
			wm1_s1  <= CW'(w_lim - DW'(1));
			hm1_s1  <= CW'(h_lim - DW'(1));
			w_s1    <= w_lim;

			op_s2   <= op_s1;
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			ps_s2   <= PW'(cs_s1) * PW'(wm1_s1);
			pt_s2   <= PW'(ct_s1) * PW'(hm1_s1);
			hm1_s2  <= hm1_s1;
			w_s2    <= w_s1;

			op_s3   <= op_s2;
			addr_s3 <= addr_s2;
			data_s3 <= data_s2;
			col_s3  <= s_round[Q_FRAC +: CW];
			row_s3  <= hm1_s2 - t_round[Q_FRAC +: CW];
			w_s3    <= w_s2;

			data_s4 <= data_s3;
			if (op_s3 == OP_WRITE) begin
				op_s4   <= OP_WRITE;
				addr_s4 <= addr_s3;
			end else begin
				op_s4   <= in_range ? OP_READ : OP_ZERO;
				addr_s4 <= idx[AW-1:0];
			end
		end
	end

endmodule

// ===== rtl/ntex_back.sv =====
// Back end: texture memory, one write or one read per cycle, and result delivery.
module ntex_back #(
	parameter int MAX_TEXELS   = ntex_pkg::MAX_TEXELS_DEF,
	parameter int RESULT_DEPTH = ntex_pkg::RESULT_DEPTH,
	parameter int AW           = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_empty,
	input  ntex_pkg::op_t                       q_op,
	input  logic [AW-1:0]                       q_addr,
	input  logic [ntex_pkg::TEXEL_W-1:0]        q_data,
	output logic                                q_pop,
	input  logic [$clog2(RESULT_DEPTH+1)-1:0]   res_count,
	output logic                                res_push,
	output logic [ntex_pkg::TEXEL_W-1:0]        res_data
);
	import ntex_pkg::*;

	localparam int CNT_W = $clog2(RESULT_DEPTH + 1) + 1;

	logic [TEXEL_W-1:0] mem [MAX_TEXELS];
	logic [TEXEL_W-1:0] rdata_s1;
	logic               pend_s1;
	logic               zero_s1;
	logic               room;
	logic               mem_we;

	// A read is issued only when its result is sure to find a free slot.
	assign room     = (CNT_W'(res_count) + CNT_W'(pend_s1)) < CNT_W'(RESULT_DEPTH);
	assign q_pop    = !q_empty && ((q_op == OP_WRITE) || room);
	assign mem_we   = q_pop && (q_op == OP_WRITE);
	assign res_push = pend_s1;
	assign res_data = zero_s1 ? '0 : rdata_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= q_pop && (q_op != OP_WRITE);
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (q_op == OP_ZERO);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[q_addr] <= q_data;
		end
		rdata_s1 <= mem[q_addr];
	end

endmodule

// ===== rtl/nearest_texture_sampler_core.sv =====
// Top level of the nearest-neighbor texture sampler with clamp and tile addressing.
// The block stores packed RGBA texels (red in bits 7:0, alpha in bits 31:24) in an
// on-chip memory of MAX_TEXELS entries and answers sample requests with the texel
// nearest to a Q15.16 coordinate pair. Items enter through a queue-style port (push,
// full): mode 0 writes write_texel at write_address and returns nothing, mode 1 samples
// with clamping, mode 2 samples with tiling (a coordinate above 1.0 keeps only its
// fraction), and mode 3 is dropped. Results leave through a second queue-style port
// (empty, pop) in the order their samples were accepted. The block takes one item per
// cycle in steady state; the single-port texture memory does one write or one read each
// cycle, and that port sets the rate. A sample's transfer in loads the first of four
// coordinate mapping stages in the front end; the sample then passes the remaining three
// stages, the queue between front and back, the memory read and the result queue before
// its result is on the result ports. The front and back ends are decoupled by a short
// queue, so a stalled result port only stops the front end once the queue has filled.
// Texels must be written before they are sampled; memory contents are undefined after
// reset and no clearing pass runs. The width and height registers reset to 256 and must
// only be written while no item is in flight.
module nearest_texture_sampler_core #(
	parameter int MAX_TEXELS    = ntex_pkg::MAX_TEXELS_DEF,
	parameter int MAX_DIMENSION = ntex_pkg::MAX_DIMENSION_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [ntex_pkg::MODE_W-1:0]    mode,
	input  logic signed [ntex_pkg::COORD_W-1:0] s_coord,
	input  logic signed [ntex_pkg::COORD_W-1:0] t_coord,
	input  logic [ntex_pkg::WADDR_W-1:0]   write_address,
	input  logic [ntex_pkg::TEXEL_W-1:0]   write_texel,
	output logic                           empty,
	input  logic                           pop,
	output logic [ntex_pkg::TEXEL_W-1:0]   sample_color,
	input  logic                           cfg_write,
	input  logic [ntex_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ntex_pkg::CFG_W-1:0]     cfg_data
);
	import ntex_pkg::*;

	localparam int AW  = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
	localparam int QW  = 2 + AW + TEXEL_W;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int RCW = $clog2(RESULT_DEPTH + 1);

	logic [CFG_W-1:0]   width_q;
	logic [CFG_W-1:0]   height_q;

	logic               advance;
	logic               q_push;
	op_t                f_op;
	logic [AW-1:0]      f_addr;
	logic [TEXEL_W-1:0] f_data;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;
	logic [QW-1:0]      q_rdata;
	logic [QCW-1:0]     q_count;
	op_t                b_op;

	logic               res_push;
	logic [TEXEL_W-1:0] res_data;
	logic [RCW-1:0]     res_count;

	// The configuration registers. Writes to indexes beyond the list do nothing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(CFG_RESET);
			height_q <= CFG_W'(CFG_RESET);
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end stalls as a whole when its last stage cannot hand off.
	assign full = !advance;

	ntex_front #(
		.MAX_TEXELS    (MAX_TEXELS),
		.MAX_DIMENSION (MAX_DIMENSION),
		.AW            (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (push && advance),
		.mode          (mode),
		.s_coord       (s_coord),
		.t_coord       (t_coord),
		.write_address (write_address),
		.write_texel   (write_texel),
		.width_cfg     (width_q),
		.height_cfg    (height_q),
		.advance       (advance),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_op          (f_op),
		.q_addr        (f_addr),
		.q_data        (f_data)
	);

	// Queue of classified items between the front and back ends.
	ntex_fifo #(
		.W     (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_op, f_addr, f_data}),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.count  (q_count)
	);

	assign q_full = (q_count == QCW'(QUEUE_DEPTH));
	assign b_op   = op_t'(q_rdata[QW-1 -: 2]);

	ntex_back #(
		.MAX_TEXELS   (MAX_TEXELS),
		.RESULT_DEPTH (RESULT_DEPTH),
		.AW           (AW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_op      (b_op),
		.q_addr    (q_rdata[TEXEL_W +: AW]),
		.q_data    (q_rdata[TEXEL_W-1:0]),
		.q_pop     (q_pop),
		.res_count (res_count),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// Result queue: the oldest sampled texel waits here for its transfer out. The back
	// end reserves a slot before it reads, so a push never meets a full queue.
	ntex_fifo #(
		.W     (TEXEL_W),
		.DEPTH (RESULT_DEPTH)
	) u_results (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_data),
		.pop    (pop),
		.rdata  (sample_color),
		.empty  (empty),
		.count  (res_count)
	);

endmodule

// ===== rtl/ntex_checker.sv =====
// Port-level checks of the texture sampler, bound to its top level.
module ntex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        push,
	input logic        full,
	input logic        empty,
	input logic        pop,
	input logic [31:0] sample_color
);

	// Leaving reset, nothing waits and the input side is open.
	a_reset_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> (empty && !full))
		else $error("sampler not empty and open after reset");

	// No result can come through the pipeline in the first cycle after reset.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |=> empty)
		else $error("result appeared too soon after reset");

	// A waiting result stays put until its transfer.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(sample_color)))
		else $error("waiting result changed or vanished");

	// Whenever an item is offered, the input side gives a clear answer.
	a_full_known: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !$isunknown(full))
		else $error("full unknown while an item is offered");

endmodule

bind nearest_texture_sampler_core ntex_checker u_ntex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.push         (push),
	.full         (full),
	.empty        (empty),
	.pop          (pop),
	.sample_color (sample_color)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the nearest-neighbor texture sampler core.
module testbench;
	import ntex_pkg::*;

	// Half clock period, reset length and the run guard, all in ns or cycles.
	localparam int CLK_HALF_NS   = 2;
	localparam int RESET_CYCLES  = 8;
	localparam int SETTLE_CYCLES = 16;
	localparam int TIMEOUT_NS    = 4_000_000;
	localparam int ITEMS_PER_SET = 100;
	localparam int REPORT_LIMIT  = 10;

	// Mode code that the block drops, and a register index beyond the list.
	localparam logic [MODE_W-1:0]    MODE_UNUSED = MODE_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_NONE    = CFG_IDX_W'(3);

	// Shadow of the texture store and dimension registers. Each accepted sample
	// queues the texel it should return; each result takes and compares the oldest.
	class color_scoreboard;
		bit [TEXEL_W-1:0] texels [MAX_TEXELS_DEF];
		bit               written [MAX_TEXELS_DEF];
		bit [CFG_W-1:0]   width_reg;
		bit [CFG_W-1:0]   height_reg;
		bit [TEXEL_W-1:0] expected_colors [$];
		int unsigned      failures;

		function new();
			width_reg  = CFG_W'(CFG_RESET);
			height_reg = CFG_W'(CFG_RESET);
			failures   = 0;
		endfunction

		function void write_reg(bit [CFG_IDX_W-1:0] index, bit [CFG_W-1:0] value);
			if (index == REG_WIDTH) begin
				width_reg = value;
			end else if (index == REG_HEIGHT) begin
				height_reg = value;
			end
		endfunction

		// A zero dimension acts as one, and anything above the maximum saturates.
		function int unsigned dim_limit(bit [CFG_W-1:0] value);
			if (value == 0) begin
				return 1;
			end
			if (value > MAX_DIMENSION_DEF) begin
				return MAX_DIMENSION_DEF;
			end
			return 32'(value);
		endfunction

		function int unsigned eff_width();
			return dim_limit(width_reg);
		endfunction

		function int unsigned eff_height();
			return dim_limit(height_reg);
		endfunction

		// Maps one Q15.16 coordinate to a texel index along an axis of dim texels.
		// Negative values pin to zero and are never wrapped. Tiling keeps only the
		// fraction of a value strictly above 1.0, so 1.0 itself lands on the last texel.
		function int unsigned map_axis(bit [COORD_W-1:0] raw, bit tile, int unsigned dim);
			bit [63:0] scaled;
			if (raw[COORD_W-1]) begin
				return 0;
			end
			if (tile && raw > Q_ONE) begin
				raw = raw & 32'h0000_FFFF;
			end
			if (raw > Q_ONE) begin
				raw = Q_ONE;
			end
			scaled = 64'(raw) * 64'(dim - 1);
			return int'((scaled + 64'(Q_HALF)) >> Q_FRAC);
		endfunction

		// Index of the nearest texel; the row runs bottom up, hence the inversion.
		function int unsigned nearest_texel_index(bit [MODE_W-1:0] m, bit [COORD_W-1:0] s,
				bit [COORD_W-1:0] t);
			int unsigned w, h, col, row;
			w   = eff_width();
			h   = eff_height();
			col = map_axis(s, m == MODE_TILE, w);
			row = (h - 1) - map_axis(t, m == MODE_TILE, h);
			return row * w + col;
		endfunction

		function void note_input(bit [MODE_W-1:0] m, bit [COORD_W-1:0] s, bit [COORD_W-1:0] t,
				bit [WADDR_W-1:0] addr, bit [TEXEL_W-1:0] texel);
			int unsigned      idx;
			bit [TEXEL_W-1:0] wanted;
			case (m) inside
				MODE_WRITE: begin
					texels[addr]  = texel;
					written[addr] = 1'b1;
				end
				MODE_CLAMP, MODE_TILE: begin
					idx    = nearest_texel_index(m, s, t);
					wanted = (idx < MAX_TEXELS_DEF) ? texels[idx] : '0;
					expected_colors.insert(expected_colors.size(), wanted);
				end
				default: ;
			endcase
		endfunction

		function void check_result(bit [TEXEL_W-1:0] actual);
			bit [TEXEL_W-1:0] wanted;
			if (expected_colors.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("%0t: sample_color %08h arrived with no sample waiting", $realtime,
						actual);
				end
				return;
			end
			wanted = expected_colors.pop_front();
			if (actual !== wanted) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("%0t: sample_color expected %08h, got %08h", $realtime, wanted,
						actual);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_colors.size();
		endfunction
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        push;
	logic                        full;
	logic [MODE_W-1:0]           mode;
	logic signed [COORD_W-1:0]   s_coord;
	logic signed [COORD_W-1:0]   t_coord;
	logic [WADDR_W-1:0]          write_address;
	logic [TEXEL_W-1:0]          write_texel;
	logic                        empty;
	logic                        pop;
	logic [TEXEL_W-1:0]          sample_color;
	logic                        cfg_write;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_W-1:0]            cfg_data;

	color_scoreboard sb = new();

	// While calm is set, neither side inserts gaps, so the block runs at full rate.
	bit calm;

	nearest_texture_sampler_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.mode         (mode),
		.s_coord      (s_coord),
		.t_coord      (t_coord),
		.write_address(write_address),
		.write_texel  (write_texel),
		.empty        (empty),
		.pop          (pop),
		.sample_color (sample_color),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #CLK_HALF_NS clk = ~clk;

	// Every input is known from time zero; reset is applied once and released.
	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		push          = 1'b0;
		mode          = '0;
		s_coord       = '0;
		t_coord       = '0;
		write_address = '0;
		write_texel   = '0;
		pop           = 1'b0;
		cfg_write     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		calm          = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Gap lengths shared by both sides: mostly back to back, some short, a few long.
	function automatic int unsigned pick_gap();
		int unsigned roll;
		if (calm) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// Coordinates weighted toward the interesting range: inside [0, 1.0], above it up to
	// 4.0 for tiling, negatives, raw 32-bit noise and the exact boundary values.
	function automatic logic [COORD_W-1:0] pick_coord();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) begin
			return $urandom_range(0, Q_ONE);
		end
		if (roll < 60) begin
			return $urandom_range(Q_ONE + 1, 4 * Q_ONE);
		end
		if (roll < 72) begin
			return $urandom;
		end
		if (roll < 80) begin
			return -$urandom_range(1, 3 * Q_ONE);
		end
		case ($urandom_range(0, 7))
			0: return '0;
			1: return Q_ONE;
			2: return Q_ONE + 1;
			3: return Q_HALF;
			4: return 32'h7FFF_FFFF;
			5: return 32'h8000_0000;
			6: return 2 * Q_ONE;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Presents one item and holds it until the block takes the transfer. The
	// push line is left high so a back-to-back item never toggles it.
	task automatic send_item(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] s,
			input logic [COORD_W-1:0] t, input logic [WADDR_W-1:0] addr,
			input logic [TEXEL_W-1:0] texel);
		push          <= 1'b1;
		mode          <= m;
		s_coord       <= s;
		t_coord       <= t;
		write_address <= addr;
		write_texel   <= texel;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_input(m, s, t, addr, texel);
	endtask

	task automatic pause_sender();
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_at(input logic [WADDR_W-1:0] addr, input logic [TEXEL_W-1:0] texel);
		send_item(MODE_WRITE, $urandom, $urandom, addr, texel);
		pause_sender();
	endtask

	// A texel that was never written has no defined contents, so a sample that
	// would land on one is preceded by a write of a random texel there.
	task automatic sample_at(input logic [MODE_W-1:0] m, input logic [COORD_W-1:0] s,
			input logic [COORD_W-1:0] t);
		int unsigned idx;
		idx = sb.nearest_texel_index(m, s, t);
		if (!sb.written[idx]) begin
			write_at(WADDR_W'(idx), $urandom);
		end
		send_item(m, s, t, WADDR_W'($urandom), $urandom);
		pause_sender();
	endtask

	task automatic send_noise();
		send_item(MODE_UNUSED, $urandom, $urandom, WADDR_W'($urandom), $urandom);
		pause_sender();
	endtask

	// Stops the sender until every expected result has been taken.
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// Registers change only with the block idle. Writes and dropped items leave
	// no result behind, so a settle period follows the last result. The spare
	// index is written too and must change nothing.
	task automatic set_dimensions(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= REG_WIDTH;
		cfg_data  <= w_raw;
		@(posedge clk);
		sb.write_reg(REG_WIDTH, w_raw);
		cfg_index <= REG_HEIGHT;
		cfg_data  <= h_raw;
		@(posedge clk);
		sb.write_reg(REG_HEIGHT, h_raw);
		cfg_index <= REG_NONE;
		cfg_data  <= junk;
		@(posedge clk);
		sb.write_reg(REG_NONE, junk);
		cfg_write <= 1'b0;
	endtask

	// Result side: each accepted transfer is checked, then pop is kept low for a
	// random gap before it is raised again.
	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				sb.check_result(sample_color);
			end
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop  <= 1'b1;
				hold = pick_gap();
			end
		end
	end

	initial begin : stimulus
		logic [CFG_W-1:0] widths [10];
		logic [CFG_W-1:0] heights [10];
		int unsigned      set_no;
		int unsigned      count;
		int unsigned      roll;
		int unsigned      span;
		logic [MODE_W-1:0] m;

		// Dimension settings per phase: reset values first, then one by one,
		// zero (acts as one), beyond the maximum, thin strips, 3 by 5, 16 by 16, random.
		widths  = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd256, 9'd1, 9'd3, 9'd16, 9'd0, 9'd0};
		heights = '{9'd256, 9'd1, 9'd0, 9'd300, 9'd1, 9'd256, 9'd5, 9'd16, 9'd0, 9'd0};
		widths[8]  = CFG_W'($urandom_range(0, 511));
		heights[8] = CFG_W'($urandom_range(0, 511));
		widths[9]  = CFG_W'($urandom_range(1, 256));
		heights[9] = CFG_W'($urandom_range(1, 256));

		@(posedge arst_n);
		@(posedge clk);

		// Directed part at the reset size of 256 by 256: store extremes, the
		// dropped mode, all four corners, clamping of out-of-range values, tiling
		// at exactly 1.0, just above it, at whole numbers and with negatives, and
		// a read right after an overwrite.
		write_at('0, '0);
		write_at('1, '1);
		write_at(16'h5A5A, 32'hA5A5_5A5A);
		send_item(MODE_UNUSED, '1, '1, '1, '1);
		pause_sender();
		sample_at(MODE_CLAMP, '0, '0);
		sample_at(MODE_CLAMP, Q_ONE, Q_ONE);
		sample_at(MODE_CLAMP, 32'h8000_0000, 32'h7FFF_FFFF);
		sample_at(MODE_CLAMP, 32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(MODE_CLAMP, Q_HALF, Q_HALF);
		sample_at(MODE_CLAMP, Q_ONE + 1, 3 * Q_ONE);
		sample_at(MODE_TILE, Q_ONE, Q_ONE);
		sample_at(MODE_TILE, Q_ONE + 1, Q_ONE + Q_HALF);
		sample_at(MODE_TILE, 2 * Q_ONE, 32'h7FFF_FFFF);
		sample_at(MODE_TILE, 32'hFFFF_FFFF, 32'h8000_0000);
		sample_at(MODE_TILE, 32'h0000_0001, 32'h0000_FFFF);
		write_at('1, 32'h1234_5678);
		sample_at(MODE_CLAMP, 32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(MODE_TILE, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

		for (set_no = 0; set_no < 10; set_no++) begin
			if (set_no != 0) begin
				set_dimensions(widths[set_no], heights[set_no]);
			end
			span  = sb.eff_width() * sb.eff_height();
			count = 0;
			while (count < ITEMS_PER_SET) begin
				// A window in the middle of each phase runs without any gaps.
				calm = (count >= 50 && count < 80);
				// A full stop of the sender partway through the third phase.
				if (set_no == 2 && count == 70) begin
					drain();
				end
				roll = $urandom_range(0, 99);
				if (roll < 5) begin
					send_noise();
				end else if (roll < 27) begin
					if ($urandom_range(0, 9) < 7) begin
						write_at(WADDR_W'($urandom_range(0, span - 1)), $urandom);
					end else begin
						write_at(WADDR_W'($urandom), $urandom);
					end
					count++;
				end else begin
					m = $urandom_range(0, 1) ? MODE_CLAMP : MODE_TILE;
					sample_at(m, pick_coord(), pick_coord());
					count++;
				end
			end
			calm = 1'b0;
		end

		// Let every result come out, then give stray ones time to show up.
		drain();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#TIMEOUT_NS;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
